@@ rtl/hpri_pkg.sv @@
// ----------------------------------------------------------------------------
// hpri_pkg
// Shared types and constants of the Hamming pivot range index.
// ----------------------------------------------------------------------------
package hpri_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int SEQ_BYTES   = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SEQ_W       = 8 * SEQ_BYTES;
    localparam int QDEPTH      = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_MATCH = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    localparam logic [1:0] REG_ORIGIN = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_MAXD   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SHIFT,
        ST_SCAN,
        ST_CHECK,
        ST_END,
        ST_ACK
    } state_t;

    // classified item handed from the front end to the back end
    typedef struct packed {
        op_t              op;
        logic [SEQ_W-1:0] seq;
        logic [3:0]       odist;
    } job_t;

    function automatic logic [3:0] hamming(input logic [SEQ_W-1:0] a,
                                           input logic [SEQ_W-1:0] b,
                                           input logic [3:0] len);
        logic [3:0] l;
        logic [3:0] d;
        l = len;
        d = '0;
        if (l == 4'd0) l = 4'd1;
        if (l > 4'(SEQ_BYTES)) l = 4'(SEQ_BYTES);
        for (int i = 0; i < SEQ_BYTES; i++) begin
            if (4'(i) < l && a[8*i +: 8] != b[8*i +: 8]) d = d + 4'd1;
        end
        return d;
    endfunction

endpackage

@@ rtl/hpri_front.sv @@
// ----------------------------------------------------------------------------
// hpri_front
// Accepts items, computes their origin distance and queues them.
// ----------------------------------------------------------------------------
module hpri_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             s_operation,
    input  logic [hpri_pkg::SEQ_W-1:0] s_sequence_bytes,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [hpri_pkg::SEQ_W-1:0] origin,
    input  logic [3:0]             seq_len,
    output hpri_pkg::job_t         job,
    output logic                   job_valid,
    input  logic                   job_ready
);
    import hpri_pkg::*;

    job_t       q_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready   = (cnt_reg != 2'(QDEPTH));
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];
    assign push      = s_valid && s_ready;
    assign pop       = job_valid && job_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg].op    <= op_t'(s_operation);
            q_reg[wp_reg].seq   <= s_sequence_bytes;
            q_reg[wp_reg].odist <= hamming(origin, s_sequence_bytes, seq_len);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

@@ rtl/hpri_back.sv @@
// ----------------------------------------------------------------------------
// hpri_back
// Sorted table, insert by shifting and query by scanning, one entry at a time.
// ----------------------------------------------------------------------------
module hpri_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hpri_pkg::job_t         job,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  logic [3:0]             seq_len,
    input  logic [3:0]             match_limit,
    output logic [1:0]             m_kind,
    output logic                   m_status,
    output logic [4:0]             m_entry_index,
    output logic [3:0]             m_distance,
    output logic [5:0]             m_match_count,
    output logic                   m_last,
    output logic                   m_valid,
    input  logic                   m_ready
);
    import hpri_pkg::*;

    logic [SEQ_W-1:0] ent_mem [MAX_ENTRIES];
    logic [3:0]       od_mem  [MAX_ENTRIES];
    logic [4:0]       num_mem [MAX_ENTRIES];

    state_t state_reg, state_next;
    job_t   cur_reg;
    logic [CNT_W-1:0] count_reg, ptr_reg, ptr_next, k_reg;
    logic [SEQ_W-1:0] rd_ent_reg;
    logic [3:0]       rd_od_reg;
    logic [4:0]       rd_num_reg;
    logic             status_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             out_free, emit, emit_match;
    logic [3:0]       diff, mdist;
    logic             hit;

    assign out_free  = !m_valid || m_ready;
    assign job_ready = (state_reg == ST_IDLE);

    // one read port: registered read of ptr-1 (find/shift) or ptr (scan)
    always_comb begin
        if (state_next == ST_FIND || state_next == ST_SHIFT)
            rd_addr = IDX_W'(ptr_next - CNT_W'(1));
        else
            rd_addr = IDX_W'(ptr_next);
    end

    always_ff @(posedge aclk) begin
        rd_ent_reg <= ent_mem[rd_addr];
        rd_od_reg  <= od_mem[rd_addr];
        rd_num_reg <= num_mem[rd_addr];
    end

    always_comb begin
        diff  = (rd_od_reg > cur_reg.odist) ? rd_od_reg - cur_reg.odist
                                            : cur_reg.odist - rd_od_reg;
        mdist = hamming(rd_ent_reg, cur_reg.seq, seq_len);
        hit   = (diff <= match_limit) && (mdist <= match_limit);
    end

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        case (state_reg)
            ST_IDLE: if (job_valid) begin
                case (job.op)
                    OP_INSERT: begin
                        ptr_next = count_reg;
                        if (count_reg >= CNT_W'(MAX_ENTRIES)) state_next = ST_ACK;
                        else if (count_reg == '0) state_next = ST_SHIFT;
                        else state_next = ST_FIND;
                    end
                    OP_QUERY: begin
                        ptr_next   = '0;
                        state_next = (count_reg == '0) ? ST_END : ST_SCAN;
                    end
                    default: state_next = ST_ACK;
                endcase
            end
            ST_FIND: begin
                // read of ptr-1 is ready: shift it up or place here
                if (rd_od_reg > cur_reg.odist) begin
                    ptr_next   = ptr_reg - CNT_W'(1);
                    state_next = (ptr_next == '0) ? ST_SHIFT : ST_FIND;
                end else begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: state_next = ST_ACK;
            ST_SCAN:  state_next = ST_CHECK;
            ST_CHECK: if (!(hit && !out_free)) begin
                ptr_next   = ptr_reg + CNT_W'(1);
                state_next = (ptr_next == count_reg) ? ST_END : ST_SCAN;
            end
            ST_END: if (out_free) state_next = ST_IDLE;
            ST_ACK: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign emit_match = (state_reg == ST_CHECK) && hit && out_free;
    assign emit = emit_match ||
                  ((state_reg == ST_END || state_reg == ST_ACK) && out_free);

    // shift happens in FIND while moving down; placement in SHIFT
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIND && rd_od_reg > cur_reg.odist) begin
            ent_mem[IDX_W'(ptr_reg)] <= rd_ent_reg;
            od_mem[IDX_W'(ptr_reg)]  <= rd_od_reg;
            num_mem[IDX_W'(ptr_reg)] <= rd_num_reg;
        end else if (state_reg == ST_SHIFT) begin
            ent_mem[IDX_W'(ptr_reg)] <= cur_reg.seq;
            od_mem[IDX_W'(ptr_reg)]  <= cur_reg.odist;
            num_mem[IDX_W'(ptr_reg)] <= 5'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && job_valid) cur_reg <= job;
        if (emit) begin
            m_kind        <= emit_match ? KIND_MATCH :
                             (state_reg == ST_END ? KIND_END : KIND_ACK);
            m_status      <= (state_reg == ST_ACK) && status_reg;
            m_entry_index <= emit_match ? rd_num_reg : 5'd0;
            m_distance    <= emit_match ? mdist : 4'd0;
            m_match_count <= (state_reg == ST_END) ? 6'(k_reg) : 6'd0;
            m_last        <= !emit_match;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ptr_reg    <= '0;
            count_reg  <= '0;
            k_reg      <= '0;
            status_reg <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            if (emit) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            if (state_reg == ST_IDLE && job_valid) begin
                k_reg      <= '0;
                status_reg <= (job.op == OP_INSERT) &&
                              (count_reg >= CNT_W'(MAX_ENTRIES));
                if (job.op == OP_CLEAR) count_reg <= '0;
            end
            if (state_reg == ST_SHIFT) count_reg <= count_reg + CNT_W'(1);
            if (emit_match) k_reg <= k_reg + CNT_W'(1);
        end
    end
endmodule

@@ rtl/hamming_pivot_range_index.sv @@
// ----------------------------------------------------------------------------
// hamming_pivot_range_index
// Table of byte sequences sorted by distance to an origin, with range query.
// ----------------------------------------------------------------------------
// Input channel s_*: operation 0 inserts, 1 queries, 2 clears the table.
// Output channel m_*: one acknowledge per insert, clear or other operation
// (status 1 when an insert finds the table full), or per query the matches in
// table order and then a count transaction with m_last set.
// The front end computes the origin distance on acceptance and holds up to
// two transactions in a queue; the back end works one item at a time over
// a table with one read port.
// Insert walks down from the end of the table, moving each larger entry up,
// then places the item and acknowledges; a full table acknowledges unchanged.
// Query reads and checks each stored entry in turn, then sends the count.
// Clear and other operations acknowledge directly.
// Reset empties the table; registers return to origin 0, length 8, max 0.
// A stalled receiver holds the back end on the pending result while the
// front queue keeps accepting until full.
// Registers: 0 origin (64 bit), 1 length, 2 max distance, at 8*i.
// ----------------------------------------------------------------------------
module hamming_pivot_range_index (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic [1:0]  s_operation,
    input  logic [63:0] s_sequence_bytes,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [1:0]  m_kind,
    output logic        m_status,
    output logic [4:0]  m_entry_index,
    output logic [3:0]  m_distance,
    output logic [5:0]  m_match_count,
    output logic        m_last,
    output logic        m_valid,
    input  logic        m_ready
);
    import hpri_pkg::*;

    logic [63:0] origin_reg;
    logic [3:0]  len_reg, maxd_reg;
    job_t        job;
    logic        job_valid, job_ready;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];

    always_comb begin
        case (reg_sel)
            REG_ORIGIN: prdata = origin_reg;
            REG_LENGTH: prdata = {60'd0, len_reg};
            REG_MAXD:   prdata = {60'd0, maxd_reg};
            default:    prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg <= '0;
            len_reg    <= 4'd8;
            maxd_reg   <= 4'd0;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_ORIGIN: origin_reg <= pwdata;
                REG_LENGTH: len_reg    <= pwdata[3:0];
                REG_MAXD:   maxd_reg   <= pwdata[3:0];
                default:    ;
            endcase
        end
    end

    hpri_front u_front (
        .aclk, .aresetn, .s_operation, .s_sequence_bytes, .s_valid, .s_ready,
        .origin(origin_reg), .seq_len(len_reg),
        .job, .job_valid, .job_ready
    );

    hpri_back u_back (
        .aclk, .aresetn, .job, .job_valid, .job_ready,
        .seq_len(len_reg), .match_limit(maxd_reg),
        .m_kind, .m_status, .m_entry_index, .m_distance, .m_match_count,
        .m_last, .m_valid, .m_ready
    );
endmodule

@@ rtl/hpri_checker.sv @@
// ----------------------------------------------------------------------------
// hpri_checker
// Port-level checks of the result channel.
// ----------------------------------------------------------------------------
module hpri_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic [1:0] m_kind,
    input logic       m_status,
    input logic       m_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_match_count
);
    import hpri_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind))
        else $error("result dropped while stalled");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_kind != KIND_MATCH)))
        else $error("last flag inconsistent with kind");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_kind == KIND_ACK)
        else $error("status outside acknowledge");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_END |-> m_match_count == 6'd0)
        else $error("count outside query end");
endmodule

bind hamming_pivot_range_index hpri_checker u_checker (
    .aclk, .aresetn, .m_kind, .m_status, .m_last, .m_valid, .m_ready,
    .m_match_count
);
